FILE: hw/rtl/mtds_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mtds_pkg;

  localparam int NUM_TIMERS_DEF = 16;
  localparam int MASK_W         = 16;
  // a wrapped remaining time is at most 2^16 below zero
  localparam int MOD_BITS       = 17;

  localparam logic [7:0]  MIN_INTERVAL_RST = 8'd10;
  localparam logic [15:0] REG_MAX          = 16'hFFFF;
  localparam logic [31:0] REMAIN_LIMIT     = 32'hFFFF_0000;
  localparam logic [31:0] TICKS_MAX        = 32'hFFFE_FFFF;

  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_STOP  = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RD,
    ST_EV,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic latch;
    logic exec;
    logic tick_init;
    logic rd;
    logic eval;
    logic mod_go;
    logic mod_commit;
    logic fin;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic need_div;
    logic last_slot;
    logic mod_done;
    logic out_free;
  } stat_t;

  function automatic logic remain_idle(input logic [31:0] r);
    return (r == 32'd0) || (r >= REMAIN_LIMIT);
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/multi_timer_deadline_scheduler_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  | Handshake          | Payload
// input    | in_valid/in_stall  | in_mode, in_timer_index, in_ticks, in_periodic, in_counter_now
// result   | out_valid/out_stall| out_compare_write, out_compare_value, out_expired_mask,
//          |                    | out_any_expired
// config   | cfg_valid/cfg_ready| cfg_min_interval
//
// Start, stop and ignored beats pass through the EXEC and OUT states to the result register.
// A tick walks the slots through the remaining-time RAM with a read state and an
// evaluate state per slot, plus a wait state for each expired periodic slot with a
// nonzero reload while the bit-serial modulo unit runs.
// Reset is synchronous; the slot RAMs need no clearing since a start writes both.
// A stalled result is held in the output register; the next beat is taken meanwhile.
module multi_timer_deadline_scheduler_top #(
  parameter int NUM_TIMERS = mtds_pkg::NUM_TIMERS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    in_mode,
  input  wire logic [3:0]                    in_timer_index,
  input  wire logic [31:0]                   in_ticks,
  input  wire logic                          in_periodic,
  input  wire logic [15:0]                   in_counter_now,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_compare_write,
  output logic [15:0]                        out_compare_value,
  output logic [mtds_pkg::MASK_W-1:0]        out_expired_mask,
  output logic                               out_any_expired,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [7:0]                    cfg_min_interval
);

  mtds_pkg::cmd_t  cmd;
  mtds_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  mtds_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  mtds_datapath #(.NumTimers(NUM_TIMERS)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_min_interval  (cfg_min_interval),
    .in_mode           (in_mode),
    .in_timer_index    (in_timer_index),
    .in_ticks          (in_ticks),
    .in_periodic       (in_periodic),
    .in_counter_now    (in_counter_now),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_compare_write (out_compare_write),
    .out_compare_value (out_compare_value),
    .out_expired_mask  (out_expired_mask),
    .out_any_expired   (out_any_expired)
  );

endmodule
`default_nettype wire

FILE: hw/rtl/mtds_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module mtds_ram #(
  parameter int Width = 32,
  parameter int Depth = 16,
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [Width-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: hw/rtl/mtds_mod.sv
`timescale 1ns / 1ps
`default_nettype none
module mtds_mod (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          go,
  input  wire logic [mtds_pkg::MOD_BITS-1:0] dividend,
  input  wire logic [31:0]                   divisor,
  output logic                               done,
  output logic      [31:0]                   remainder
);

  localparam int CW = $clog2(mtds_pkg::MOD_BITS + 1);

  logic [31:0]                   rem_r, rem_nxt;
  logic [31:0]                   dsr_r, dsr_nxt;
  logic [mtds_pkg::MOD_BITS-1:0] dvd_r, dvd_nxt;
  logic [CW-1:0]                 cnt_r, cnt_nxt;
  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [32:0]                   sh;

  always_comb begin
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    dvd_nxt  = dvd_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sh       = {rem_r, dvd_r[mtds_pkg::MOD_BITS-1]};
    if (go) begin
      rem_nxt  = 32'd0;
      dsr_nxt  = divisor;
      dvd_nxt  = dividend;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // restoring step: one dividend bit a cycle
      if (sh >= {1'b0, dsr_r}) begin
        sh = sh - {1'b0, dsr_r};
      end
      rem_nxt = sh[31:0];
      dvd_nxt = {dvd_r[mtds_pkg::MOD_BITS-2:0], 1'b0};
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(mtds_pkg::MOD_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    dvd_r <= dvd_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule
`default_nettype wire

FILE: hw/rtl/mtds_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module mtds_datapath #(
  parameter int NumTimers = mtds_pkg::NUM_TIMERS_DEF,
  localparam int IW = (NumTimers > 1) ? $clog2(NumTimers) : 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire mtds_pkg::cmd_t                cmd,
  output mtds_pkg::stat_t                    stat,
  input  wire logic                          cfg_valid,
  input  wire logic                          cfg_ready,
  input  wire logic [7:0]                    cfg_min_interval,
  input  wire logic [1:0]                    in_mode,
  input  wire logic [3:0]                    in_timer_index,
  input  wire logic [31:0]                   in_ticks,
  input  wire logic                          in_periodic,
  input  wire logic [15:0]                   in_counter_now,
  input  wire logic                          out_stall,
  output logic                               out_valid,
  output logic                               out_compare_write,
  output logic [15:0]                        out_compare_value,
  output logic [mtds_pkg::MASK_W-1:0]        out_expired_mask,
  output logic                               out_any_expired
);

  logic [7:0]  min_r;
  logic [15:0] last_r;
  logic [1:0]  mode_r;
  logic [3:0]  idx_r;
  logic [31:0] ticks_r;
  logic        per_r;
  logic [15:0] now_r;
  logic [15:0] delta_r;
  logic [IW-1:0] i_r;
  logic [15:0] best_r;
  logic [31:0] r_r;
  logic [31:0] rl_r;
  logic [NumTimers-1:0] active_r, active_nxt;
  logic [NumTimers-1:0] per_flag_r, per_flag_nxt;
  logic        res_cw_r;
  logic [15:0] res_cv_r;
  logic [mtds_pkg::MASK_W-1:0] mask_r, mask_nxt;
  logic        out_valid_r;
  logic        out_cw_r;
  logic [15:0] out_cv_r;
  logic [mtds_pkg::MASK_W-1:0] out_mask_r;
  logic        out_any_r;

  logic [31:0] q_rem, q_rl;
  logic [IW-1:0] slot_idx;
  logic        idx_ok, start_ok, stop_ok;
  logic [15:0] delta_now;
  logic [31:0] t_sat, t_min, rem_start;
  logic        skip, expd, kill;
  logic [31:0] r_ev, r_neg, r_new, mod_rem;
  logic        mod_done;
  logic [15:0] best_min;
  logic        rem_we, rl_we;
  logic [IW-1:0] w_addr;
  logic [31:0] rem_wdata;

  assign idx_ok    = 32'(idx_r) < NumTimers;
  assign start_ok  = (mode_r == mtds_pkg::MODE_START) && idx_ok;
  assign stop_ok   = (mode_r == mtds_pkg::MODE_STOP) && idx_ok;
  assign slot_idx  = IW'(idx_r);
  assign delta_now = now_r - last_r;
  assign t_sat     = (ticks_r > mtds_pkg::TICKS_MAX) ? mtds_pkg::TICKS_MAX : ticks_r;
  assign t_min     = (t_sat < {24'd0, min_r}) ? {24'd0, min_r} : t_sat;
  assign rem_start = t_min + {16'd0, delta_now};

  assign skip  = !active_r[i_r] || mtds_pkg::remain_idle(q_rem);
  assign r_ev  = q_rem - {16'd0, delta_r};
  assign expd  = !skip && mtds_pkg::remain_idle(r_ev);
  assign kill  = expd && (!per_flag_r[i_r] || (q_rl == 32'd0));
  assign r_neg = 32'd0 - r_ev;
  assign r_new = rl_r - mod_rem;
  assign best_min = (best_r < {8'd0, min_r}) ? {8'd0, min_r} : best_r;

  assign rem_we    = (cmd.exec && start_ok) || (cmd.eval && !skip) || cmd.mod_commit;
  assign rl_we     = cmd.exec && start_ok;
  assign w_addr    = cmd.exec ? slot_idx : i_r;
  assign rem_wdata = cmd.exec ? rem_start : (cmd.mod_commit ? r_new : r_ev);

  mtds_ram #(.Width(32), .Depth(NumTimers)) u_rem_ram (
    .clk   (clk),
    .we    (rem_we),
    .waddr (w_addr),
    .wdata (rem_wdata),
    .raddr (i_r),
    .rdata (q_rem)
  );

  mtds_ram #(.Width(32), .Depth(NumTimers)) u_rl_ram (
    .clk   (clk),
    .we    (rl_we),
    .waddr (w_addr),
    .wdata (t_min),
    .raddr (i_r),
    .rdata (q_rl)
  );

  mtds_mod u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (cmd.mod_go),
    .dividend  (r_neg[mtds_pkg::MOD_BITS-1:0]),
    .divisor   (q_rl),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  always_comb begin
    active_nxt   = active_r;
    per_flag_nxt = per_flag_r;
    mask_nxt     = mask_r;
    if (cmd.exec && start_ok) begin
      active_nxt[slot_idx]   = 1'b1;
      per_flag_nxt[slot_idx] = per_r;
    end else if (cmd.exec && stop_ok) begin
      active_nxt[slot_idx] = 1'b0;
    end
    if (cmd.eval && kill) begin
      active_nxt[i_r] = 1'b0;
    end
    if (cmd.exec || cmd.tick_init) begin
      mask_nxt = '0;
    end
    for (int k = 0; k < mtds_pkg::MASK_W; k++) begin
      if (k < NumTimers && (cmd.eval || cmd.mod_go) && expd && i_r == IW'(k)) begin
        mask_nxt[k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r       <= mtds_pkg::MIN_INTERVAL_RST;
      last_r      <= 16'd0;
      active_r    <= '0;
      per_flag_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        min_r <= cfg_min_interval;
      end
      if (cmd.tick_init) begin
        last_r <= now_r;
      end
      active_r   <= active_nxt;
      per_flag_r <= per_flag_nxt;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    if (cmd.latch) begin
      mode_r  <= in_mode;
      idx_r   <= in_timer_index;
      ticks_r <= in_ticks;
      per_r   <= in_periodic;
      now_r   <= in_counter_now;
    end
    mask_r <= mask_nxt;
    if (cmd.exec) begin
      res_cw_r <= start_ok;
      res_cv_r <= start_ok ? (now_r + {8'd0, min_r}) : 16'd0;
    end
    if (cmd.tick_init) begin
      delta_r <= delta_now;
      i_r     <= '0;
      best_r  <= mtds_pkg::REG_MAX;
    end
    if (cmd.eval) begin
      i_r <= i_r + IW'(1);
      if (!skip && !kill && r_ev < {16'd0, best_r}) begin
        best_r <= r_ev[15:0];
      end
    end
    if (cmd.mod_go) begin
      r_r  <= r_ev;
      rl_r <= q_rl;
    end
    if (cmd.mod_commit) begin
      i_r <= i_r + IW'(1);
      if (r_new < {16'd0, best_r}) begin
        best_r <= r_new[15:0];
      end
    end
    if (cmd.fin) begin
      res_cw_r <= 1'b1;
      res_cv_r <= now_r + best_min;
    end
    if (cmd.load_out) begin
      out_cw_r   <= res_cw_r;
      out_cv_r   <= res_cv_r;
      out_mask_r <= mask_r;
      out_any_r  <= |mask_r;
    end
  end

  assign stat.is_tick   = (mode_r == mtds_pkg::MODE_TICK);
  assign stat.need_div  = expd && !kill;
  assign stat.last_slot = (i_r == IW'(NumTimers - 1));
  assign stat.mod_done  = mod_done;
  assign stat.out_free  = !out_valid_r || !out_stall;

  assign out_valid         = out_valid_r;
  assign out_compare_write = out_cw_r;
  assign out_compare_value = out_cv_r;
  assign out_expired_mask  = out_mask_r;
  assign out_any_expired   = out_any_r;

  a_any_matches_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_any_r == (out_mask_r != '0)))
    else $error("any_expired disagrees with expired_mask");

  // the held wrap value must lie in the idle range when the modulo result is committed
  a_wrap_in_idle_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mod_commit |-> mtds_pkg::remain_idle(r_r))
    else $error("periodic reload of an unexpired slot");

  a_reload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mod_commit |-> (rl_r != 32'd0))
    else $error("modulo by zero reload");

endmodule
`default_nettype wire

FILE: hw/rtl/mtds_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module mtds_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire mtds_pkg::stat_t stat,
  output mtds_pkg::cmd_t       cmd
);

  mtds_pkg::state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mtds_pkg::ST_IDLE: if (in_valid) state_nxt = mtds_pkg::ST_EXEC;
      mtds_pkg::ST_EXEC: state_nxt = stat.is_tick ? mtds_pkg::ST_RD : mtds_pkg::ST_OUT;
      mtds_pkg::ST_RD:   state_nxt = mtds_pkg::ST_EV;
      mtds_pkg::ST_EV: begin
        if (stat.need_div) state_nxt = mtds_pkg::ST_DIV;
        else if (stat.last_slot) state_nxt = mtds_pkg::ST_FIN;
        else state_nxt = mtds_pkg::ST_RD;
      end
      mtds_pkg::ST_DIV: begin
        if (stat.mod_done) begin
          state_nxt = stat.last_slot ? mtds_pkg::ST_FIN : mtds_pkg::ST_RD;
        end
      end
      mtds_pkg::ST_FIN:  state_nxt = mtds_pkg::ST_OUT;
      mtds_pkg::ST_OUT:  if (stat.out_free) state_nxt = mtds_pkg::ST_IDLE;
      default:           state_nxt = mtds_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      mtds_pkg::ST_IDLE: begin
        in_stall  = 1'b0;
        cmd.latch = in_valid;
      end
      mtds_pkg::ST_EXEC: begin
        cmd.tick_init = stat.is_tick;
        cmd.exec      = !stat.is_tick;
      end
      mtds_pkg::ST_RD:   cmd.rd = 1'b1;
      mtds_pkg::ST_EV: begin
        cmd.mod_go = stat.need_div;
        cmd.eval   = !stat.need_div;
      end
      mtds_pkg::ST_DIV:  cmd.mod_commit = stat.mod_done;
      mtds_pkg::ST_FIN:  cmd.fin = 1'b1;
      mtds_pkg::ST_OUT:  cmd.load_out = stat.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mtds_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.exec, cmd.tick_init, cmd.eval, cmd.mod_go, cmd.mod_commit,
              cmd.fin, cmd.load_out}))
    else $error("conflicting datapath commands");

  a_div_follows_go: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mod_go |=> (state_r == mtds_pkg::ST_DIV))
    else $error("modulo started outside the wait state");

  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != mtds_pkg::ST_IDLE) |-> in_stall)
    else $error("input taken while busy");

endmodule
`default_nettype wire

FILE: sim/multi_timer_deadline_scheduler_top_tb.sv
`timescale 1ns / 1ps
module multi_timer_deadline_scheduler_top_tb;

  localparam int NT = 16;
  localparam int CYCLE_LIMIT = 2000000;
  localparam logic [1:0] MODE_BAD = 2'd3;

  typedef struct packed {
    logic        cw;
    logic [15:0] cv;
    logic [15:0] mask;
    logic        any;
  } sched_res_t;

  typedef struct {
    logic [1:0]  mode;
    logic [3:0]  idx;
    logic [31:0] ticks;
    logic        per;
    logic [15:0] now;
    logic        chk;
    sched_res_t  res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_mode = '0;
  logic [3:0] in_timer_index = '0;
  logic [31:0] in_ticks = '0;
  logic in_periodic = 1'b0;
  logic [15:0] in_counter_now = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_compare_write;
  logic [15:0] out_compare_value;
  logic [15:0] out_expired_mask;
  logic out_any_expired;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_min_interval = '0;

  multi_timer_deadline_scheduler_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_mode(in_mode),
    .in_timer_index(in_timer_index), .in_ticks(in_ticks), .in_periodic(in_periodic),
    .in_counter_now(in_counter_now),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_compare_write(out_compare_write), .out_compare_value(out_compare_value),
    .out_expired_mask(out_expired_mask), .out_any_expired(out_any_expired),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_min_interval(cfg_min_interval)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  logic [7:0]  pm_min;
  logic        pm_act [NT];
  logic        pm_per [NT];
  logic [31:0] pm_rel [NT];
  logic [31:0] pm_rem [NT];
  logic [15:0] pm_last;

  sched_res_t pending_res[$];
  int n_err = 0;
  int n_res = 0;
  int n_exp = 0;
  int n_in = 0;
  int cycles = 0;
  bit quiet = 1'b0;

  function automatic logic rem_off(logic [31:0] r);
    return (r == 32'd0) || (r >= mtds_pkg::REMAIN_LIMIT);
  endfunction

  function automatic logic [31:0] at_least_min(logic [31:0] v);
    return (v < {24'd0, pm_min}) ? {24'd0, pm_min} : v;
  endfunction

  function automatic sched_res_t schedule_step(logic [1:0] mode, logic [3:0] idx,
                                               logic [31:0] ticks, logic per,
                                               logic [15:0] now);
    sched_res_t o;
    logic [31:0] t, dl, best, r, rl, d, bm;
    logic [15:0] d16;
    o = '0;
    d16 = now - pm_last;
    dl = {16'd0, d16};
    if (mode == mtds_pkg::MODE_START) begin
      t = (ticks > mtds_pkg::TICKS_MAX) ? mtds_pkg::TICKS_MAX : ticks;
      t = at_least_min(t);
      pm_act[idx] = 1'b1;
      pm_per[idx] = per;
      pm_rel[idx] = t;
      pm_rem[idx] = t + dl;
      o.cw = 1'b1;
      o.cv = now + {8'd0, pm_min};
    end else if (mode == mtds_pkg::MODE_STOP) begin
      pm_act[idx] = 1'b0;
    end else if (mode == mtds_pkg::MODE_TICK) begin
      best = 32'h0000_FFFF;
      pm_last = now;
      for (int i = 0; i < NT; i++) begin
        if (pm_act[i] && !rem_off(pm_rem[i])) begin
          r = pm_rem[i] - dl;
          if (rem_off(r)) begin
            rl = pm_rel[i];
            o.mask[i] = 1'b1;
            if (!pm_per[i] || rl == 32'd0) begin
              pm_rem[i] = r;
              pm_act[i] = 1'b0;
            end else begin
              d = (r == 32'd0) ? 32'd0 : (32'd0 - r);
              r = rl - (d % rl);
            end
          end
          if (pm_act[i]) begin
            pm_rem[i] = r;
            if (r < best) best = r;
          end
        end
      end
      bm = at_least_min(best);
      o.cw = 1'b1;
      o.cv = now + bm[15:0];
    end
    o.any = (o.mask != 16'd0);
    return o;
  endfunction

  // result checking
  always @(posedge clk) begin
    sched_res_t got, want;
    if (rst_n) cycles <= cycles + 1;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_compare_write, out_compare_value, out_expired_mask, out_any_expired};
      n_res++;
      if (got.any) n_exp++;
      if (pending_res.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected result beat %h", got);
      end else begin
        want = pending_res.pop_front();
        if (got !== want) begin
          n_err++;
          if (n_err <= 10)
            $display("mismatch: expected cw=%0b cv=%h mask=%h any=%0b,",
                     want.cw, want.cv, want.mask, want.any,
                     " got cw=%0b cv=%h mask=%h any=%0b",
                     got.cw, got.cv, got.mask, got.any);
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  // receiver stall
  always @(negedge clk) begin
    out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 6);
  end

  task automatic send_beat(logic [1:0] mode, logic [3:0] idx, logic [31:0] ticks,
                           logic per, logic [15:0] now, logic chk, sched_res_t res);
    sched_res_t p;
    do @(negedge clk); while (!quiet && $urandom_range(99) < 6);
    in_mode <= mode;
    in_timer_index <= idx;
    in_ticks <= ticks;
    in_periodic <= per;
    in_counter_now <= now;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    p = schedule_step(mode, idx, ticks, per, now);
    if (chk && p !== res) begin
      n_err++;
      if (n_err <= 10) $display("table row disagrees with predictor: %h vs %h", res, p);
    end
    pending_res.push_back(p);
    n_in++;
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain_all();
    while (pending_res.size() != 0) @(negedge clk);
    repeat (2 * NT + 4 + 18 * NT + 20) @(negedge clk);
  endtask

  task automatic set_min(logic [7:0] v);
    cfg_min_interval <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    pm_min = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  stim_row_t dir_rows[$];

  function automatic stim_row_t mk(logic [1:0] m, logic [3:0] i, logic [31:0] t, logic p,
                                   logic [15:0] n, logic c, sched_res_t r);
    stim_row_t s;
    s = '{m, i, t, p, n, c, r};
    return s;
  endfunction

  initial begin
    logic [15:0] now;
    logic [1:0] m;
    logic [31:0] t;
    int k, w;
    pm_min = mtds_pkg::MIN_INTERVAL_RST;
    pm_last = '0;
    for (int i = 0; i < NT; i++) begin
      pm_act[i] = 0; pm_per[i] = 0; pm_rel[i] = 0; pm_rem[i] = 0;
    end
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table, reset min_interval 10
    dir_rows.push_back(mk(mtds_pkg::MODE_TICK, 4'd0, 32'd0, 1'b0, 16'd0, 1,
                          '{1, 16'hFFFF, 16'd0, 0}));
    dir_rows.push_back(mk(mtds_pkg::MODE_STOP, 4'd15, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 1, '0));
    dir_rows.push_back(mk(MODE_BAD, 4'd7, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 1, '0));
    dir_rows.push_back(mk(mtds_pkg::MODE_START, 4'd0, 32'd0, 1'b0, 16'd100, 1,
                          '{1, 16'd110, 16'd0, 0}));
    dir_rows.push_back(mk(mtds_pkg::MODE_START, 4'd1, 32'd50, 1'b1, 16'd100, 0, '0));
    dir_rows.push_back(mk(mtds_pkg::MODE_START, 4'd15, 32'hFFFF_FFFF, 1'b0, 16'hFFF6, 1,
                          '{1, 16'h0000, 16'd0, 0}));
    dir_rows.push_back(mk(mtds_pkg::MODE_START, 4'd14, 32'hFFFE_FFF0, 1'b1, 16'd5, 0, '0));
    dir_rows.push_back(mk(mtds_pkg::MODE_TICK, 4'd0, 32'd0, 1'b0, 16'd200, 0, '0));
    dir_rows.push_back(mk(mtds_pkg::MODE_TICK, 4'd0, 32'd0, 1'b0, 16'd500, 0, '0));
    dir_rows.push_back(mk(mtds_pkg::MODE_START, 4'd2, 32'd3, 1'b1, 16'd500, 0, '0));
    dir_rows.push_back(mk(mtds_pkg::MODE_TICK, 4'd0, 32'd0, 1'b0, 16'd499, 0, '0));
    dir_rows.push_back(mk(mtds_pkg::MODE_STOP, 4'd2, 32'd0, 1'b0, 16'd0, 1, '0));
    dir_rows.push_back(mk(mtds_pkg::MODE_START, 4'd3, 32'd65535, 1'b1, 16'hFFFF, 0, '0));
    dir_rows.push_back(mk(mtds_pkg::MODE_TICK, 4'd0, 32'd0, 1'b0, 16'hFFFF, 0, '0));
    dir_rows.push_back(mk(mtds_pkg::MODE_TICK, 4'd0, 32'd0, 1'b0, 16'h0000, 0, '0));
    foreach (dir_rows[j])
      send_beat(dir_rows[j].mode, dir_rows[j].idx, dir_rows[j].ticks, dir_rows[j].per,
                dir_rows[j].now, dir_rows[j].chk, dir_rows[j].res);
    drain_all();

    // zero min_interval: zero reload and inactive-remaining starts
    set_min(8'd0);
    send_beat(mtds_pkg::MODE_START, 4'd4, 32'd0, 1'b1, pm_last, 0, '0);
    send_beat(mtds_pkg::MODE_START, 4'd5, 32'd0, 1'b0, pm_last + 16'd7, 0, '0);
    send_beat(mtds_pkg::MODE_TICK, 4'd0, 32'd0, 1'b0, pm_last + 16'd9, 0, '0);
    send_beat(mtds_pkg::MODE_TICK, 4'd0, 32'd0, 1'b0, pm_last, 0, '0);
    drain_all();

    // random phases over several min_interval settings
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_min(8'd255);
        1: set_min(8'd1);
        2: set_min(8'($urandom_range(255)));
        3: set_min(8'd0);
        default: set_min(8'd10);
      endcase
      quiet = (ph == 2);
      now = pm_last;
      for (k = 0; k < 80; k++) begin
        w = $urandom_range(99);
        now = now + 16'($urandom_range(w < 50 ? 300 : 65535));
        m = (w < 45) ? mtds_pkg::MODE_START : (w < 55) ? mtds_pkg::MODE_STOP :
            (w < 95) ? mtds_pkg::MODE_TICK : MODE_BAD;
        w = $urandom_range(9);
        t = (w < 6) ? $urandom_range(400) : (w < 8) ? $urandom_range(70000) : $urandom();
        send_beat(m, 4'($urandom_range(15)), t, 1'($urandom), now, 0, '0);
      end
      // hold off until all results are in
      while (pending_res.size() != 0) @(negedge clk);
      quiet = 1'b0;
      drain_all();
    end

    $display("%0d beats sent, %0d results checked, %0d with expiries", n_in, n_res, n_exp);
    $display("min_interval swept over 0, 1, 10, 255 and a random value");
    if (n_err == 0 && pending_res.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d results missing", n_err, pending_res.size());
      $display("simulation failed");
    end
    $finish;
  end
endmodule

FILE: multi_timer_deadline_scheduler_top.f
hw/rtl/mtds_pkg.sv
hw/rtl/mtds_ram.sv
hw/rtl/mtds_mod.sv
hw/rtl/mtds_datapath.sv
hw/rtl/mtds_ctrl.sv
hw/rtl/multi_timer_deadline_scheduler_top.sv
sim/multi_timer_deadline_scheduler_top_tb.sv
